[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the gate rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define RIAG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("riag assertion failed");

// clocked assertion, also checked across reset
`define RIAG_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("riag assertion failed");

`endif

[hw/rtl/riag_pkg.sv]
// ----------------------------------------------------------------------------
// riag_pkg
// shared types, constants and helpers of the random interval audio gate
// ----------------------------------------------------------------------------
`default_nettype none

package riag_pkg;

    // default widths
    localparam int SAMPLE_BITS   = 24;
    localparam int COUNT_BITS    = 21;
    localparam int CFG_LEN_BITS  = 21;
    localparam int GAIN_BITS     = 17;
    localparam int RAND_BITS     = 32;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 3;

    // gain and random source constants
    localparam logic [GAIN_BITS-1:0] UNITY_GAIN = 17'h10000;
    localparam logic [RAND_BITS-1:0] LFSR_MASK  = 32'h8020_0003;

    // register reset values
    localparam logic [CFG_LEN_BITS-1:0] SILENCE_RST = 21'd96000;
    localparam logic [CFG_LEN_BITS-1:0] MIN_RST     = 21'd4800;
    localparam logic [CFG_LEN_BITS-1:0] MAX_RST     = 21'd240000;
    localparam logic [GAIN_BITS-1:0]    STEP_RST    = 17'd137;
    localparam logic [RAND_BITS-1:0]    SEED_RST    = 32'd1;

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SILENCE = 3'd0,
        CFG_MIN     = 3'd1,
        CFG_MAX     = 3'd2,
        CFG_STEP    = 3'd3,
        CFG_SEED    = 3'd4
    } t_cfg_idx;

    // one register write
    typedef struct packed {
        logic                     we;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_wr;

    // per-frame gate result handed to the scaling stage
    typedef struct packed {
        logic [GAIN_BITS-1:0] gain;
        logic                 open;
    } t_frame;

    // one step of the galois lfsr
    function automatic logic [RAND_BITS-1:0] lfsr_step(input logic [RAND_BITS-1:0] s);
        logic [RAND_BITS-1:0] sh;
        sh = {1'b0, s[RAND_BITS-1:1]};
        return s[0] ? (sh ^ LFSR_MASK) : sh;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/riag_draw.sv]
// ----------------------------------------------------------------------------
// riag_draw
// random source and open-phase length precompute, one draw ahead
// ----------------------------------------------------------------------------
`default_nettype none

module riag_draw #(
    parameter int COUNT_BITS = riag_pkg::COUNT_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  riag_pkg::t_cfg_wr       i_cfg,
    input  wire                     i_draw,
    output logic [COUNT_BITS-1:0]   o_dur,
    output logic                    o_dur_ok
);

    localparam int RB = riag_pkg::RAND_BITS;
    localparam int PW = RB + COUNT_BITS + 1;

    logic [riag_pkg::CFG_LEN_BITS-1:0] r_min;
    logic [riag_pkg::CFG_LEN_BITS-1:0] r_max;
    logic [RB-1:0]                     r_rand;
    logic [RB-1:0]                     n_rand;
    logic [COUNT_BITS-1:0]             r_dur;
    logic [COUNT_BITS-1:0]             n_dur;
    logic                              r_dur_ok;

    logic [COUNT_BITS-1:0] lo;
    logic [COUNT_BITS-1:0] hi_raw;
    logic [COUNT_BITS-1:0] hi;
    logic [COUNT_BITS:0]   span1;
    logic [RB-1:0]         r_next;
    logic [PW-1:0]         prod;

    // next lfsr state: seed load, draw or hold
    always_comb begin
        if (i_cfg.we && (i_cfg.idx == riag_pkg::CFG_SEED)) begin
            n_rand = (i_cfg.data == '0) ? RB'(1) : i_cfg.data;
        end else if (i_draw) begin
            n_rand = riag_pkg::lfsr_step(r_rand);
        end else begin
            n_rand = r_rand;
        end
    end

    // length of the draw that will use the upcoming state
    always_comb begin
        lo     = COUNT_BITS'(r_min);
        hi_raw = COUNT_BITS'(r_max);
        hi     = (hi_raw < lo) ? lo : hi_raw;
        span1  = {1'b0, hi - lo} + (COUNT_BITS + 1)'(1);
        r_next = riag_pkg::lfsr_step(n_rand);
        prod   = PW'(r_next) * PW'(span1);
        n_dur  = lo + prod[RB +: COUNT_BITS];
    end

    // bound registers and random state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= riag_pkg::MIN_RST;
            r_max    <= riag_pkg::MAX_RST;
            r_rand   <= riag_pkg::SEED_RST;
            r_dur_ok <= 1'b0;
        end else begin
            r_rand   <= n_rand;
            r_dur_ok <= !i_cfg.we;
            if (i_cfg.we && (i_cfg.idx == riag_pkg::CFG_MIN)) begin
                r_min <= i_cfg.data[riag_pkg::CFG_LEN_BITS-1:0];
            end
            if (i_cfg.we && (i_cfg.idx == riag_pkg::CFG_MAX)) begin
                r_max <= i_cfg.data[riag_pkg::CFG_LEN_BITS-1:0];
            end
        end
    end

    // precomputed length, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_dur <= n_dur;
    end

    assign o_dur    = r_dur;
    assign o_dur_ok = r_dur_ok;

endmodule

`default_nettype wire

[hw/rtl/riag_ctrl.sv]
// ----------------------------------------------------------------------------
// riag_ctrl
// phase counter, gate flag and gain ramp, updated once per accepted frame
// ----------------------------------------------------------------------------
`default_nettype none

module riag_ctrl #(
    parameter int COUNT_BITS = riag_pkg::COUNT_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  riag_pkg::t_cfg_wr       i_cfg,
    input  wire                     i_acc,
    input  wire  [COUNT_BITS-1:0]   i_dur,
    output logic                    o_draw,
    output riag_pkg::t_frame        o_frame
);

    localparam int GB = riag_pkg::GAIN_BITS;

    logic [riag_pkg::CFG_LEN_BITS-1:0] r_silence;
    logic [GB-1:0]                     r_step;
    logic                              r_open;
    logic                              r_first;
    logic [COUNT_BITS-1:0]             r_count;
    logic [GB-1:0]                     r_gain;

    logic [COUNT_BITS-1:0] cnt_a;
    logic [COUNT_BITS-1:0] cnt_b;
    logic [COUNT_BITS-1:0] n_count;
    logic                  n_open;
    logic [GB-1:0]         n_gain;
    logic [GB:0]           up_sum;

    // phase check: first draw, then flip at zero
    always_comb begin
        cnt_a = r_first ? i_dur : r_count;
        if (cnt_a == '0) begin
            n_open = !r_open;
            cnt_b  = r_open ? COUNT_BITS'(r_silence) : i_dur;
        end else begin
            n_open = r_open;
            cnt_b  = cnt_a;
        end
        n_count = (cnt_b != '0) ? cnt_b - COUNT_BITS'(1) : '0;
    end

    // a draw consumes the precomputed length
    assign o_draw = i_acc && (r_first || ((r_count == '0) && !r_open));

    // linear ramp toward unity or zero, clamped
    always_comb begin
        up_sum = {1'b0, r_gain} + {1'b0, r_step};
        if (n_open) begin
            n_gain = (up_sum > {1'b0, riag_pkg::UNITY_GAIN}) ?
                     riag_pkg::UNITY_GAIN : up_sum[GB-1:0];
        end else begin
            n_gain = (r_gain > r_step) ? r_gain - r_step : '0;
        end
    end

    assign o_frame.gain = n_gain;
    assign o_frame.open = n_open;

    // gate state and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence <= riag_pkg::SILENCE_RST;
            r_step    <= riag_pkg::STEP_RST;
            r_open    <= 1'b1;
            r_first   <= 1'b1;
            r_count   <= '0;
            r_gain    <= riag_pkg::UNITY_GAIN;
        end else begin
            if (i_cfg.we && (i_cfg.idx == riag_pkg::CFG_SILENCE)) begin
                r_silence <= i_cfg.data[riag_pkg::CFG_LEN_BITS-1:0];
            end
            if (i_cfg.we && (i_cfg.idx == riag_pkg::CFG_STEP)) begin
                r_step <= i_cfg.data[GB-1:0];
            end
            if (i_acc) begin
                r_open  <= n_open;
                r_first <= 1'b0;
                r_count <= n_count;
                r_gain  <= n_gain;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/riag_scale.sv]
// ----------------------------------------------------------------------------
// riag_scale
// gain multiply of both channels into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module riag_scale #(
    parameter int SAMPLE_BITS = riag_pkg::SAMPLE_BITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    input  wire  signed [SAMPLE_BITS-1:0]       i_left,
    input  wire  signed [SAMPLE_BITS-1:0]       i_right,
    input  riag_pkg::t_frame                    i_frame,
    output logic                                o_ready,
    output logic                                o_valid,
    input  wire                                 i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]       o_left,
    output logic signed [SAMPLE_BITS-1:0]       o_right,
    output logic [riag_pkg::GAIN_BITS-1:0]      o_gain,
    output logic                                o_open
);

    localparam int GB = riag_pkg::GAIN_BITS;
    localparam int PW = SAMPLE_BITS + GB + 1;

    logic signed [GB:0]   gain_s;
    logic signed [PW-1:0] prod_l;
    logic signed [PW-1:0] prod_r;
    logic                 r_valid;

    // floored q1.16 products
    assign gain_s = $signed({1'b0, i_frame.gain});
    assign prod_l = PW'(i_left) * PW'(gain_s);
    assign prod_r = PW'(i_right) * PW'(gain_s);

    assign o_ready = !r_valid || i_out_ready;

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            o_left  <= prod_l[SAMPLE_BITS+15:16];
            o_right <= prod_r[SAMPLE_BITS+15:16];
            o_gain  <= i_frame.gain;
            o_open  <= i_frame.open;
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

[hw/rtl/random_interval_audio_gate_core.sv]
// ----------------------------------------------------------------------------
// random_interval_audio_gate_core
// stereo gate with random open phases, fixed closed phases and a gain ramp
// ----------------------------------------------------------------------------
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  left_sample, right_sample
// m_axis    out  m_axis_tvalid / m_axis_tready  left_out, right_out, gain_now,
//                                               gate_open_now
// cfg       in   i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// an accepted frame passes the input stage register and then the scale output
// register to m_axis; the gain update and the multiply each fit in one register
// stage, so the rate is one frame per cycle while m_axis is ready and no cfg
// write is pending; the open-phase length comes from a multiply one draw ahead
// s_axis_tready is low for one cycle after reset and after each cfg write
// while that precomputed length is refreshed; no clearing pass
// a stall on m_axis backs up through both stages to s_axis_tready
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module random_interval_audio_gate_core #(
    parameter int SAMPLE_BITS = riag_pkg::SAMPLE_BITS,
    parameter int COUNT_BITS  = riag_pkg::COUNT_BITS
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    // fields from bit 0: left_sample, right_sample
    input  wire  [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
    input  wire                                       s_axis_tvalid,
    output logic                                      s_axis_tready,
    // fields from bit 0: left_out, right_out, gain_now, gate_open_now
    output logic [((2*SAMPLE_BITS+riag_pkg::GAIN_BITS+8)/8)*8-1:0] m_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire                                       m_axis_tready,
    input  wire                                       i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire  [riag_pkg::CFG_IDX_BITS-1:0]         i_cfg_index,
    input  wire  [riag_pkg::CFG_DATA_BITS-1:0]        i_cfg_data
);

    localparam int GB  = riag_pkg::GAIN_BITS;
    localparam int MDW = ((2*SAMPLE_BITS+GB+8)/8)*8;

    riag_pkg::t_cfg_wr cfg;
    riag_pkg::t_frame  frame;
    riag_pkg::t_frame  r_s1_frame;

    logic                          in_acc;
    logic                          cfg_acc;
    logic                          draw;
    logic [COUNT_BITS-1:0]         dur;
    logic                          dur_ok;
    logic                          s1_free;
    logic                          out_free;
    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_left;
    logic signed [SAMPLE_BITS-1:0] r_s1_right;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic [GB-1:0]                 out_gain;
    logic                          out_open;

    // handshakes
    assign o_cfg_ready   = 1'b1;
    assign cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign s1_free       = !r_s1_valid || out_free;
    assign s_axis_tready = s1_free && dur_ok;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign cfg.we   = cfg_acc;
    assign cfg.idx  = i_cfg_index;
    assign cfg.data = i_cfg_data;

    riag_draw #(
        .COUNT_BITS (COUNT_BITS)
    ) u_draw (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_draw   (draw),
        .o_dur    (dur),
        .o_dur_ok (dur_ok)
    );

    riag_ctrl #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_acc   (in_acc),
        .i_dur   (dur),
        .o_draw  (draw),
        .o_frame (frame)
    );

    // input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= in_acc;
        end
    end

    // input stage payload with this frame's gain
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_left  <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
            r_s1_right <= $signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
            r_s1_frame <= frame;
        end
    end

    riag_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .i_left      (r_s1_left),
        .i_right     (r_s1_right),
        .i_frame     (r_s1_frame),
        .o_ready     (out_free),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_left      (out_left),
        .o_right     (out_right),
        .o_gain      (out_gain),
        .o_open      (out_open)
    );

    // pack result word
    assign m_axis_tdata = MDW'({out_open, out_gain, out_right, out_left});

    // checks
    `RIAG_ASSERT(a_acc_fills_stage, i_clk, i_rst_n, in_acc |=> r_s1_valid)
    `RIAG_ASSERT(a_cfg_holds_input, i_clk, i_rst_n, cfg_acc |=> !s_axis_tready)
    `RIAG_ASSERT(a_gain_bounded, i_clk, i_rst_n,
        r_s1_valid |-> (r_s1_frame.gain <= riag_pkg::UNITY_GAIN))
    `RIAG_ASSERT_NR(a_reset_empties, i_clk, !i_rst_n |=> (!m_axis_tvalid && !r_s1_valid))

endmodule

`default_nettype wire
